@@ rtl/core/ept_pkg.sv @@
package ept_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } t_pose;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [31:0] trans_x;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [31:0] trans_y;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
        logic signed [31:0] trans_z;
    } t_xform;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [17:0] ONE_Q14     = 18'sd16384;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:  atan_q30 = 34'sh03243F6A8;
            5'd1:  atan_q30 = 34'sh01DAC6705;
            5'd2:  atan_q30 = 34'sh00FADBAFC;
            5'd3:  atan_q30 = 34'sh007F56EA6;
            5'd4:  atan_q30 = 34'sh003FEAB76;
            5'd5:  atan_q30 = 34'sh001FFD55B;
            5'd6:  atan_q30 = 34'sh000FFFAAA;
            5'd7:  atan_q30 = 34'sh0007FFF55;
            5'd8:  atan_q30 = 34'sh0003FFFEA;
            5'd9:  atan_q30 = 34'sh0001FFFFD;
            5'd10: atan_q30 = 34'sh0000FFFFF;
            5'd11: atan_q30 = 34'sh00007FFFF;
            5'd12: atan_q30 = 34'sh00003FFFF;
            5'd13: atan_q30 = 34'sh00001FFFF;
            5'd14: atan_q30 = 34'sh00000FFFF;
            5'd15: atan_q30 = 34'sh000007FFF;
            5'd16: atan_q30 = 34'sh000003FFF;
            5'd17: atan_q30 = 34'sh000001FFF;
            5'd18: atan_q30 = 34'sh000000FFF;
            5'd19: atan_q30 = 34'sh0000007FF;
            5'd20: atan_q30 = 34'sh0000003FF;
            5'd21: atan_q30 = 34'sh0000001FF;
            5'd22: atan_q30 = 34'sh0000000FF;
            5'd23: atan_q30 = 34'sh00000007F;
            default: atan_q30 = '0;
        endcase
    endfunction

    function automatic logic signed [17:0] clamp_q14(input logic signed [35:0] v);
        if (v > 36'(ONE_Q14)) begin
            clamp_q14 = ONE_Q14;
        end else if (v < -36'(ONE_Q14)) begin
            clamp_q14 = -ONE_Q14;
        end else begin
            clamp_q14 = v[17:0];
        end
    endfunction

    function automatic logic signed [17:0] mul_q14(input logic signed [17:0] a,
                                                   input logic signed [17:0] b);
        logic signed [35:0] p;
        p = a * b + 36'sd8192;
        mul_q14 = 18'(p >>> 14);
    endfunction

endpackage

@@ rtl/core/ept_cordic.sv @@
module ept_cordic
    import ept_pkg::*;
#(
    parameter int STAGES = 14
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_ang,
    output logic signed [17:0]  o_sin,
    output logic signed [17:0]  o_cos
);

    localparam int NS = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

    logic signed [33:0] r_x [0:NS];
    logic signed [33:0] r_y [0:NS];
    logic signed [33:0] r_z [0:NS];
    logic               r_flip [0:NS];
    logic signed [33:0] n_z0;
    logic               n_flip0;
    logic signed [35:0] n_xr, n_yr;

    // quadrant fold
    always_comb begin
        n_z0 = 34'(i_ang) <<< 17;
        n_flip0 = 1'b0;
        if (n_z0 > HALF_PI_Q30) begin
            n_z0 = n_z0 - PI_Q30;
            n_flip0 = 1'b1;
        end else if (n_z0 < -HALF_PI_Q30) begin
            n_z0 = n_z0 + PI_Q30;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_flip[0] <= n_flip0;
            for (int i = 0; i < NS; i++) begin
                if (!r_z[i][33]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q30(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q30(5'(i));
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    always_comb begin
        n_xr = (36'(r_x[NS]) + 36'sd32768) >>> 16;
        n_yr = (36'(r_y[NS]) + 36'sd32768) >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_flip[NS] ? -clamp_q14(n_xr) : clamp_q14(n_xr);
            o_sin <= r_flip[NS] ? -clamp_q14(n_yr) : clamp_q14(n_yr);
        end
    end

endmodule

@@ rtl/core/euler_pose_to_transform_core.sv @@
// throughput: one pose per cycle while the output is not stalled, set by the fully pipelined cordic and multipliers
// the whole pipe advances when the output register is empty or being taken
// reset: synchronous active low, clears all valid bits; payload not reset
module euler_pose_to_transform_core
    import ept_pkg::*;
#(
    parameter int CORDIC_STAGES = 14
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_pose  i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_xform o_data
);

    localparam int NS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int CL  = NS + 2;
    localparam int LAT = CL + 3;

    logic en;
    logic [LAT-1:0] r_vld;
    logic signed [31:0] r_tx [0:LAT-1];
    logic signed [31:0] r_ty [0:LAT-1];
    logic signed [31:0] r_tz [0:LAT-1];
    logic signed [17:0] sz, cz, sy, cy, sx, cx;
    logic signed [17:0] r_sz, r_cz, r_sx, r_cx, r_czsy, r_szsy;
    logic signed [17:0] r_p00, r_p10, r_p20, r_p21, r_p22;
    logic signed [17:0] r_q00, r_q10, r_q20, r_q21, r_q22;
    logic signed [17:0] r_a1, r_b1, r_a2, r_b2, r_a4, r_b4, r_a5, r_b5;
    t_xform r_out;

    assign en = !o_valid || i_ready;
    assign o_ready = en;

    ept_cordic #(.STAGES(CORDIC_STAGES)) u_z (
        .i_clk(i_clk), .i_en(en), .i_ang(i_data.yaw), .o_sin(sz), .o_cos(cz));
    ept_cordic #(.STAGES(CORDIC_STAGES)) u_y (
        .i_clk(i_clk), .i_en(en), .i_ang(i_data.pitch), .o_sin(sy), .o_cos(cy));
    ept_cordic #(.STAGES(CORDIC_STAGES)) u_x (
        .i_clk(i_clk), .i_en(en), .i_ang(i_data.roll), .o_sin(sx), .o_cos(cx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx[0] <= i_data.pos_x;
            r_ty[0] <= i_data.pos_y;
            r_tz[0] <= i_data.pos_z;
            for (int k = 1; k < LAT; k++) begin
                r_tx[k] <= r_tx[k-1];
                r_ty[k] <= r_ty[k-1];
                r_tz[k] <= r_tz[k-1];
            end
            // first products
            r_sz <= sz; r_cz <= cz; r_sx <= sx; r_cx <= cx;
            r_czsy <= mul_q14(cz, sy);
            r_szsy <= mul_q14(sz, sy);
            r_p00 <= mul_q14(cz, cy);
            r_p10 <= mul_q14(sz, cy);
            r_p20 <= -sy;
            r_p21 <= mul_q14(cy, sx);
            r_p22 <= mul_q14(cy, cx);
            // second products
            r_a1 <= mul_q14(r_czsy, r_sx); r_b1 <= mul_q14(r_sz, r_cx);
            r_a2 <= mul_q14(r_czsy, r_cx); r_b2 <= mul_q14(r_sz, r_sx);
            r_a4 <= mul_q14(r_szsy, r_sx); r_b4 <= mul_q14(r_cz, r_cx);
            r_a5 <= mul_q14(r_szsy, r_cx); r_b5 <= mul_q14(r_cz, r_sx);
            // products delayed so rot_00 etc stay aligned: first-stage ones are registered again in r_q
            r_q00 <= r_p00;
            r_q10 <= r_p10;
            r_q20 <= r_p20;
            r_q21 <= r_p21;
            r_q22 <= r_p22;
            // sums and output register
            r_out.rot_00 <= r_q00[15:0];
            r_out.rot_10 <= r_q10[15:0];
            r_out.rot_20 <= r_q20[15:0];
            r_out.rot_21 <= r_q21[15:0];
            r_out.rot_22 <= r_q22[15:0];
            r_out.rot_01 <= 16'(clamp_q14(36'(r_a1) - 36'(r_b1)));
            r_out.rot_02 <= 16'(clamp_q14(36'(r_a2) + 36'(r_b2)));
            r_out.rot_11 <= 16'(clamp_q14(36'(r_a4) + 36'(r_b4)));
            r_out.rot_12 <= 16'(clamp_q14(36'(r_a5) - 36'(r_b5)));
            r_out.trans_x <= r_tx[LAT-2];
            r_out.trans_y <= r_ty[LAT-2];
            r_out.trans_z <= r_tz[LAT-2];
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_data  = r_out;

endmodule

@@ rtl/core/ept_checker.sv @@
module ept_checker
    import ept_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   o_ready,
    input logic   o_valid,
    input logic   i_ready,
    input t_xform o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat dropped while stalled");

    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input not ready while output free");

    a_r20: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.rot_20 <= 16'sd16384 && o_data.rot_20 >= -16'sd16384)
        else $error("rot_20 out of range");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind euler_pose_to_transform_core ept_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data));

@@ bench/tb_euler_pose_to_transform_core.sv @@
module tb_euler_pose_to_transform_core;
    import ept_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES      = 14;
    localparam int LATENCY     = STAGES + 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam longint PI_L    = 64'sd3373259426;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint GAIN    = 64'sd652032874;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_pose  i_data;
    logic   o_valid;
    logic   i_ready;
    t_xform o_data;

    t_xform xform_queue[$];
    int     mismatch_count;
    int     cycle_count;
    bit     idle_enable;
    int     hold_off;

    longint atan_tab[24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    euler_pose_to_transform_core #(.CORDIC_STAGES(STAGES)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat_unit(input longint v);
        if (v > 16384) begin
            return 16384;
        end
        if (v < -16384) begin
            return -16384;
        end
        return v;
    endfunction

    function automatic longint round_mul(input longint a, input longint b);
        return (a * b + 8192) >>> 14;
    endfunction

    task automatic sine_cosine(input logic signed [15:0] ang,
                               output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = longint'(ang) * 131072;
        x = GAIN;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI) begin
            z = z - PI_L;
            flip = 1'b1;
        end else if (z < -HALF_PI) begin
            z = z + PI_L;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_tab[i];
            end
            x = nx;
        end
        x = sat_unit((x + 32768) >>> 16);
        y = sat_unit((y + 32768) >>> 16);
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endtask

    task automatic predict_transform(input t_pose p, output t_xform t);
        longint sz, cz, sy, cy, sx, cx, czsy, szsy;
        sine_cosine(p.yaw, sz, cz);
        sine_cosine(p.pitch, sy, cy);
        sine_cosine(p.roll, sx, cx);
        czsy = round_mul(cz, sy);
        szsy = round_mul(sz, sy);
        t.rot_00  = 16'(round_mul(cz, cy));
        t.rot_01  = 16'(sat_unit(round_mul(czsy, sx) - round_mul(sz, cx)));
        t.rot_02  = 16'(sat_unit(round_mul(czsy, cx) + round_mul(sz, sx)));
        t.rot_10  = 16'(round_mul(sz, cy));
        t.rot_11  = 16'(sat_unit(round_mul(szsy, sx) + round_mul(cz, cx)));
        t.rot_12  = 16'(sat_unit(round_mul(szsy, cx) - round_mul(cz, sx)));
        t.rot_20  = 16'(-sy);
        t.rot_21  = 16'(round_mul(cy, sx));
        t.rot_22  = 16'(round_mul(cy, cx));
        t.trans_x = p.pos_x;
        t.trans_y = p.pos_y;
        t.trans_z = p.pos_z;
    endtask

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, field, got, want);
        mismatch_count++;
    endtask

    task automatic compare_field(input string field, input longint got,
                                 input longint want);
        if (got != want) begin
            report_mismatch(field, got, want);
        end
    endtask

    task automatic send_pose(input t_pose p);
        t_xform t;
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_transform(p, t);
        i_valid <= 1'b1;
        i_data  <= p;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        xform_queue.push_back(t);
    endtask

    function automatic logic signed [15:0] random_angle();
        return 16'($signed($urandom_range(0, 51472)) - 25736);
    endfunction

    function automatic t_pose random_pose();
        t_pose p;
        p.pos_x = $urandom;
        p.pos_y = $urandom;
        p.pos_z = $urandom;
        p.yaw   = random_angle();
        p.pitch = random_angle();
        p.roll  = random_angle();
        return p;
    endfunction

    task automatic test_extremes();
        logic signed [15:0] angles[12] = '{
            16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868, 16'sd12869,
            -16'sd12869, 16'sd12867, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1
        };
        t_pose p;
        for (int k = 0; k < 12; k++) begin
            p.pos_x = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            p.pos_y = (k % 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
            p.pos_z = (k % 3) ? 32'h5555_5555 : 32'hAAAA_AAAA;
            p.yaw   = angles[k];
            p.pitch = angles[(k + 4) % 12];
            p.roll  = angles[(k + 8) % 12];
            send_pose(p);
        end
        for (int k = 0; k < 4; k++) begin
            p = random_pose();
            p.yaw   = angles[k + 8];
            p.pitch = angles[k + 8];
            p.roll  = angles[k + 8];
            send_pose(p);
        end
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_pose(random_pose());
        end
    endtask

    task automatic test_backpressure();
        hold_off = 60;
        for (int k = 0; k < 40; k++) begin
            send_pose(random_pose());
        end
    endtask

    // output side: random stalls while idle_enable is set, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready  <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_xform want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (xform_queue.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = xform_queue.pop_front();
                compare_field("rot_00", o_data.rot_00, want.rot_00);
                compare_field("rot_01", o_data.rot_01, want.rot_01);
                compare_field("rot_02", o_data.rot_02, want.rot_02);
                compare_field("trans_x", o_data.trans_x, want.trans_x);
                compare_field("rot_10", o_data.rot_10, want.rot_10);
                compare_field("rot_11", o_data.rot_11, want.rot_11);
                compare_field("rot_12", o_data.rot_12, want.rot_12);
                compare_field("trans_y", o_data.trans_y, want.trans_y);
                compare_field("rot_20", o_data.rot_20, want.rot_20);
                compare_field("rot_21", o_data.rot_21, want.rot_21);
                compare_field("rot_22", o_data.rot_22, want.rot_22);
                compare_field("trans_z", o_data.trans_z, want.trans_z);
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        hold_off       = 0;
        idle_enable    = 1'b1;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_random(250);
        test_backpressure();
        test_random(150);
        idle_enable = 1'b0;
        test_random(100);
        i_valid <= 1'b0;
        while (xform_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 5) @(posedge i_clk);
        if (mismatch_count == 0 && xform_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ept_pkg.sv
rtl/core/ept_cordic.sv
rtl/core/euler_pose_to_transform_core.sv
rtl/core/ept_checker.sv
bench/tb_euler_pose_to_transform_core.sv
